FILE: design/pipq_pkg.sv
// pipq_pkg: shared constants and types for the point-in-polygon quadrant block
// no dependencies; compiled first

package pipq_pkg;

    // sizes of the vertex store and of the coordinate fields
    localparam int MAX_VERTICES = 64;
    localparam int COORD_W      = 32;
    localparam int VADDR_W      = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int VIDX_W       = 6;
    localparam int VCNT_W       = 7;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_SHAPE = 1'd1;

    // winding total: reported width and internal accumulator width
    localparam int TOTAL_W = 10;
    localparam int ACC_W   = ($clog2(MAX_VERTICES) + 3 > TOTAL_W) ?
                             $clog2(MAX_VERTICES) + 3 : TOTAL_W;

    // intercept test operands
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OPEN  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [1:0]                status_t;
    typedef logic signed [TOTAL_W-1:0] total_t;

endpackage

FILE: design/pipq_in_if.sv
// pipq_in_if: input channel (vertex writes and point queries)
// depends on pipq_pkg

interface pipq_in_if;
    import pipq_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [VIDX_W-1:0]   vertex_index;
    coord_t              coord_x;
    coord_t              coord_y;

    modport source (output valid, op, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, op, vertex_index, coord_x, coord_y, output ready);
endinterface

FILE: design/pipq_out_if.sv
// pipq_out_if: result channel (one beat per query)
// depends on pipq_pkg

interface pipq_out_if;
    import pipq_pkg::*;

    logic     valid;
    logic     ready;
    logic     inside_res;
    status_t  status;
    total_t   winding_total;

    modport source (output valid, inside_res, status, winding_total, input ready);
    modport sink   (input valid, inside_res, status, winding_total, output ready);
endinterface

FILE: design/point_in_polygon_quadrant.sv
// point_in_polygon_quadrant: quadrant winding-number containment test
// depends on pipq_pkg, pipq_in_if, pipq_out_if
//
// Usage
//   in_ch carries two kinds of beat. op = write stores (coord_x, coord_y) in
//   vertex slot vertex_index and gives no result. op = query tests the point
//   (coord_x, coord_y) against vertices 0 .. n-1 and the closing edge, and
//   gives exactly one beat on out_ch: inside_res, status, winding_total.
//   cfg_we/cfg_index/cfg_data set vertex_count (saturated to 64) and
//   closed_shape; write them only while the block is idle.
// Query flow
//   A write leaves the block idle. A query with n vertices streams n + 1 reads
//   out of the vertex memory, one per cycle, through a three-stage
//   quadrant/multiply/compare pipe, then waits for the pipe to drain and
//   loads its result in the finish state. An open polygon or an empty count
//   skips the reads and goes straight to the finish state. One query is in
//   flight at a time: no new beat is taken until it has finished.
// Reset and stall
//   Reset clears the count, the closed flag and all control; the vertex
//   memory keeps no reset and must be written before it is used. The result
//   sits in an output register: new beats are taken while it waits, but a
//   further query finishes only once the receiver has taken the last result.

module point_in_polygon_quadrant (
    input  logic                              clk,
    input  logic                              rst_n,
    pipq_in_if.sink                           in_ch,
    pipq_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [pipq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pipq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pipq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    // quadrant of a vertex around the point: 1 right/above .. 4 right/not above
    function automatic logic [2:0] quad_of(coord_t vx, coord_t vy, coord_t px, coord_t py);
        logic right;
        logic above;
        right = vx > px;
        above = vy > py;
        if (right)
            return above ? 3'd1 : 3'd4;
        else
            return above ? 3'd2 : 3'd3;
    endfunction

    // vertex memory: {x, y} per slot
    logic [2*COORD_W-1:0] vertex_mem [MAX_VERTICES];

    // control state
    logic [1:0]        state_reg, state_next;
    logic [VCNT_W-1:0] count_reg, count_next;
    logic              closed_reg, closed_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              rd_valid_reg, rd_first_reg;
    logic              s2_valid_reg, s3_valid_reg;
    logic              out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    status_t           status_reg, status_next;

    // payload state
    coord_t            px_reg, py_reg;
    logic [2*COORD_W-1:0] rd_data_reg;
    coord_t            prev_x_reg, prev_y_reg;
    logic [2:0]        prev_quad_reg;
    logic signed [DIFF_W-1:0] s2_a_reg, s2_d_reg, s2_b_reg, s2_c_reg;
    logic signed [2:0] s2_delta_reg, s3_delta_reg;
    logic              s2_two_reg, s3_two_reg;
    logic              s2_dpos_reg, s3_dpos_reg;
    logic signed [PROD_W-1:0] s3_lhs_reg, s3_rhs_reg;
    logic              out_inside_reg;
    status_t           out_status_reg;
    total_t            out_total_reg;

    logic              in_fire;
    logic              wr_en;
    logic              rd_en;
    logic [VADDR_W-1:0] rd_addr;
    logic              fin_load;
    logic [CNT_W-1:0]  n_sat;
    coord_t            cur_x, cur_y;
    logic [2:0]        cur_quad;
    logic signed [3:0] delta_raw;
    logic signed [2:0] delta_map;
    logic              is_two;
    logic signed [PROD_W-1:0] lhs_next, rhs_next;
    logic              right_of;
    logic signed [2:0] eff_delta;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign wr_en       = in_fire && (in_ch.op == OP_WRITE)
                         && (int'(in_ch.vertex_index) < MAX_VERTICES);

    // saturated vertex count
    assign n_sat = (CNT_W'(count_reg) > CNT_W'(MAX_VERTICES)) ?
                   CNT_W'(MAX_VERTICES) : CNT_W'(count_reg);

    // read sequence 0, 1, .., n-1 and vertex 0 again for the closing edge
    assign rd_en   = (state_reg == S_RUN);
    assign rd_addr = (rd_cnt_reg == n_reg) ? '0 : rd_cnt_reg[VADDR_W-1:0];

    // memory: writes only in idle, reads only while running, so no overlap
    always_ff @(posedge clk)
    begin
        if (wr_en)
            vertex_mem[VADDR_W'(in_ch.vertex_index)] <= {in_ch.coord_x, in_ch.coord_y};
        if (rd_en)
            rd_data_reg <= vertex_mem[rd_addr];
    end

    // stage 1: quadrant of the vertex just read, edge differences
    assign cur_x     = rd_data_reg[2*COORD_W-1:COORD_W];
    assign cur_y     = rd_data_reg[COORD_W-1:0];
    assign cur_quad  = quad_of(cur_x, cur_y, px_reg, py_reg);
    assign delta_raw = $signed({1'b0, cur_quad}) - $signed({1'b0, prev_quad_reg});

    always_comb
    begin
        delta_map = delta_raw[2:0];
        case (delta_raw)
            4'sd3:   delta_map = -3'sd1;
            -4'sd3:  delta_map = 3'sd1;
            default: delta_map = delta_raw[2:0];
        endcase
    end
    assign is_two = (delta_raw == 4'sd2) || (delta_raw == -4'sd2);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            px_reg <= in_ch.coord_x;
            py_reg <= in_ch.coord_y;
        end
        if (rd_valid_reg)
        begin
            prev_x_reg    <= cur_x;
            prev_y_reg    <= cur_y;
            prev_quad_reg <= cur_quad;
            s2_a_reg      <= DIFF_W'(cur_x) - DIFF_W'(px_reg);
            s2_d_reg      <= DIFF_W'(prev_y_reg) - DIFF_W'(cur_y);
            s2_b_reg      <= DIFF_W'(cur_y) - DIFF_W'(py_reg);
            s2_c_reg      <= DIFF_W'(prev_x_reg) - DIFF_W'(cur_x);
            s2_delta_reg  <= delta_map;
            s2_two_reg    <= is_two;
            s2_dpos_reg   <= prev_y_reg > cur_y;
        end
        // stage 2: exact cross products of the intercept test
        if (s2_valid_reg)
        begin
            s3_lhs_reg   <= lhs_next;
            s3_rhs_reg   <= rhs_next;
            s3_delta_reg <= s2_delta_reg;
            s3_two_reg   <= s2_two_reg;
            s3_dpos_reg  <= s2_dpos_reg;
        end
        if (fin_load)
        begin
            out_inside_reg <= (acc_reg == ACC_W'(4)) || (acc_reg == -ACC_W'(4));
            out_status_reg <= status_reg;
            out_total_reg  <= acc_reg[TOTAL_W-1:0];
        end
    end

    assign lhs_next = PROD_W'(s2_a_reg) * PROD_W'(s2_d_reg);
    assign rhs_next = PROD_W'(s2_b_reg) * PROD_W'(s2_c_reg);

    // stage 3: intercept side, sign of a half-turn crossing
    assign right_of  = s3_dpos_reg ? (s3_lhs_reg > s3_rhs_reg) : (s3_lhs_reg < s3_rhs_reg);
    assign eff_delta = (s3_two_reg && right_of) ? -s3_delta_reg : s3_delta_reg;

    assign fin_load = (state_reg == S_FIN) && (!out_valid_reg || out_ch.ready);

    // sequencer, configuration and accumulator
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        closed_next    = closed_reg;
        n_next         = n_reg;
        rd_cnt_next    = rd_cnt_reg;
        acc_next       = acc_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VERTEX_COUNT: count_next  = cfg_data[VCNT_W-1:0];
                CFG_CLOSED_SHAPE: closed_next = cfg_data[0];
                default: ;
            endcase
        end

        if (s3_valid_reg)
            acc_next = acc_reg + ACC_W'(eff_delta);

        if (out_ch.ready)
            out_valid_next = 1'b0;
        if (fin_load)
            out_valid_next = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_ch.op == OP_QUERY))
                begin
                    acc_next    = '0;
                    rd_cnt_next = '0;
                    n_next      = n_sat;
                    if (!closed_reg)
                    begin
                        status_next = ST_OPEN;
                        state_next  = S_FIN;
                    end
                    else if (n_sat == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        state_next  = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == n_reg)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !s2_valid_reg && !s3_valid_reg)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fin_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            closed_reg    <= 1'b0;
            n_reg         <= '0;
            rd_cnt_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            rd_first_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            closed_reg    <= closed_next;
            n_reg         <= n_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_valid_reg  <= rd_en;
            rd_first_reg  <= rd_en && (rd_cnt_reg == '0);
            s2_valid_reg  <= rd_valid_reg && !rd_first_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            status_reg    <= status_next;
        end
    end

    // result beat
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.inside_res    = out_inside_reg;
    assign out_ch.status        = out_status_reg;
    assign out_ch.winding_total = out_total_reg;

    // pipe is empty whenever a new item can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(rd_valid_reg || s2_valid_reg || s3_valid_reg))
        else $error("edge pipe busy while idle");

    // a result is only loaded out of the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result raised outside finish");

    // reads stay inside the vertices in use
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> ((rd_cnt_reg <= n_reg) && (n_reg != '0)))
        else $error("vertex read beyond count");

    // an error status never comes with a non-zero total or an inside result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |->
            ((out_total_reg == '0) && !out_inside_reg))
        else $error("error result carries a total");
endmodule
